### rtl/mm_pkg.sv
// mm_pkg: shared constants, types and helper functions of the matrix multiply core.
// No dependencies; all rtl/ modules reference it by scoped names.
`default_nettype none

package mm_pkg;

  // Sizing
  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;
  localparam int DIM_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W      = $clog2(MAX_DIM + 1);
  localparam int ADDR_W     = 2 * DIM_W;
  localparam int DEPTH      = 1 << ADDR_W;
  localparam int PROD_W     = 34;
  localparam int MUL_W      = 2 * ELEM_WIDTH;
  localparam int ACC_W      = (MUL_W + 4 > PROD_W + 1) ? (MUL_W + 4) : (PROD_W + 1);

  // Field widths fixed by the interface
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 3;
  localparam int VAL_W   = 16;
  localparam int REG_W   = 4;
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 4;

  // Saturation bounds of the product value
  localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (PROD_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  // Register indexes
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_INNER = 2'd1;
  localparam logic [1:0] REG_COLS  = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_A  = 2'd0,
    REQ_LOAD_B  = 2'd1,
    REQ_COMPUTE = 2'd2
  } mm_req_e;

  // Effective sizes used by the controller
  typedef struct packed {
    logic [CNT_W-1:0] nr;
    logic [CNT_W-1:0] nk;
    logic [CNT_W-1:0] nc;
  } mm_dims_t;

  // Tag that travels with one operand pair through the datapath
  typedef struct packed {
    logic             first;
    logic             lastk;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mm_tag_t;

  // Controller to datapath
  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    mm_tag_t           tag;
  } mm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_busy;
  } mm_status_t;

  // Zero acts as one, oversize acts as MAX_DIM
  function automatic logic [CNT_W-1:0] eff_dim(input logic [REG_W-1:0] r);
    logic [CNT_W-1:0] res;
    if (r == '0) begin
      res = CNT_W'(1);
    end else if (32'(r) > MAX_DIM) begin
      res = CNT_W'(MAX_DIM);
    end else begin
      res = CNT_W'(r);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/matrix_multiply_core.sv
// matrix_multiply_core: top level of the fixed-point matrix multiply core.
// Depends on mm_pkg, mm_regs, mm_ctrl and mm_datapath.
//
//   channel   | handshake                          | payload
//   ----------+------------------------------------+-------------------------------------
//   request   | start / busy                       | req_type_i, row_index_i, col_index_i,
//             |                                    | element_value_i
//   result    | out_valid_o (one-cycle strobe)     | out_row_o, out_col_o, product_value_o,
//             |                                    | last_element_o
//   config    | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// A load leaves busy low, so the next request transfers in the next cycle.
// A compute runs one multiply-accumulate per cycle through the single multiplier; results
// stream out row-major, one after each full pass over the inner index.
// Reset is asynchronous and active low; the operand stores hold no reset value.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module matrix_multiply_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [mm_pkg::REQ_W-1:0]            req_type_i,
  input  wire logic [mm_pkg::IDX_W-1:0]            row_index_i,
  input  wire logic [mm_pkg::IDX_W-1:0]            col_index_i,
  input  wire logic signed [mm_pkg::VAL_W-1:0]     element_value_i,
  output logic                                     out_valid_o,
  output logic [mm_pkg::IDX_W-1:0]                 out_row_o,
  output logic [mm_pkg::IDX_W-1:0]                 out_col_o,
  output logic signed [mm_pkg::PROD_W-1:0]         product_value_o,
  output logic                                     last_element_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mm_pkg::PADDR_W-1:0]          paddr,
  input  wire logic [mm_pkg::PDATA_W-1:0]          pwdata,
  output logic      [mm_pkg::PDATA_W-1:0]          prdata,
  output logic                                     pready
);

  mm_pkg::mm_dims_t   dims;
  mm_pkg::mm_cmd_t    cmd;
  mm_pkg::mm_status_t status;

  mm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims_o  (dims)
  );

  mm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .req_type_i  (req_type_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .dims_i      (dims),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mm_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .last_element_o  (last_element_o)
  );

  // Results only come out of a running compute
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy)
    else $error("result strobe outside a compute");

  // A compute request holds off further requests
  a_compute_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_type_i == mm_pkg::REQ_COMPUTE)) |=> busy)
    else $error("compute transfer did not start the sequencer");

  // Loads and unused codes leave busy low and produce no result
  a_load_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_type_i != mm_pkg::REQ_COMPUTE)) |=> (!busy && !out_valid_o))
    else $error("load transfer left the core busy or produced a result");

  // The final result ends the run on the next cycle
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_element_o |=> (!busy && !out_valid_o))
    else $error("activity after the final result");

endmodule

`default_nettype wire

### rtl/mm_regs.sv
// mm_regs: APB-style configuration registers for the matrix sizes.
// Depends on mm_pkg.
`default_nettype none

module mm_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mm_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mm_pkg::PDATA_W-1:0]  pwdata,
  output logic      [mm_pkg::PDATA_W-1:0]  prdata,
  output logic                             pready,
  output mm_pkg::mm_dims_t                 dims_o
);

  logic [mm_pkg::REG_W-1:0] rows_q, inner_q, cols_q;
  logic [1:0]               idx;
  logic                     wr_en;
  logic [mm_pkg::REG_W-1:0] rd_val;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= mm_pkg::REG_W'(mm_pkg::MAX_DIM);
      inner_q <= mm_pkg::REG_W'(mm_pkg::MAX_DIM);
      cols_q  <= mm_pkg::REG_W'(mm_pkg::MAX_DIM);
    end else if (wr_en) begin
      case (idx)
        mm_pkg::REG_ROWS:  rows_q  <= pwdata[mm_pkg::REG_W-1:0];
        mm_pkg::REG_INNER: inner_q <= pwdata[mm_pkg::REG_W-1:0];
        mm_pkg::REG_COLS:  cols_q  <= pwdata[mm_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mm_pkg::REG_ROWS:  rd_val = rows_q;
      mm_pkg::REG_INNER: rd_val = inner_q;
      mm_pkg::REG_COLS:  rd_val = cols_q;
      default:           rd_val = '0;
    endcase
  end

  assign prdata    = mm_pkg::PDATA_W'(rd_val);
  assign dims_o.nr = mm_pkg::eff_dim(rows_q);
  assign dims_o.nk = mm_pkg::eff_dim(inner_q);
  assign dims_o.nc = mm_pkg::eff_dim(cols_q);

endmodule

`default_nettype wire

### rtl/mm_ctrl.sv
// mm_ctrl: request decode and row/column/inner loop sequencer.
// Depends on mm_pkg; drives mm_datapath through mm_cmd_t.
`default_nettype none

module mm_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic [mm_pkg::REQ_W-1:0]       req_type_i,
  input  wire logic [mm_pkg::IDX_W-1:0]       row_index_i,
  input  wire logic [mm_pkg::IDX_W-1:0]       col_index_i,
  input  wire mm_pkg::mm_dims_t               dims_i,
  input  wire mm_pkg::mm_status_t             status_i,
  output mm_pkg::mm_cmd_t                     cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } mm_state_e;

  mm_state_e                state_q, state_d;
  logic [mm_pkg::DIM_W-1:0] i_q, i_d, j_q, j_d, z_q, z_d;
  logic                     accept;
  logic                     last_i, last_j, last_z;
  logic                     row_in_a, col_in_a, row_in_b, col_in_b;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && (state_q == ST_IDLE);

  assign last_i = (mm_pkg::CNT_W'(i_q) + mm_pkg::CNT_W'(1)) == dims_i.nr;
  assign last_j = (mm_pkg::CNT_W'(j_q) + mm_pkg::CNT_W'(1)) == dims_i.nc;
  assign last_z = (mm_pkg::CNT_W'(z_q) + mm_pkg::CNT_W'(1)) == dims_i.nk;

  assign row_in_a = mm_pkg::CNT_W'(row_index_i) < dims_i.nr;
  assign col_in_a = mm_pkg::CNT_W'(col_index_i) < dims_i.nk;
  assign row_in_b = mm_pkg::CNT_W'(row_index_i) < dims_i.nk;
  assign col_in_b = mm_pkg::CNT_W'(col_index_i) < dims_i.nc;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    z_d     = z_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req_type_i == mm_pkg::REQ_COMPUTE)) begin
          state_d = ST_RUN;
          i_d     = '0;
          j_d     = '0;
          z_d     = '0;
        end
      end
      ST_RUN: begin
        // advance inner index, then column, then row
        if (!last_z) begin
          z_d = z_q + mm_pkg::DIM_W'(1);
        end else begin
          z_d = '0;
          if (!last_j) begin
            j_d = j_q + mm_pkg::DIM_W'(1);
          end else begin
            j_d = '0;
            if (!last_i) begin
              i_d = i_q + mm_pkg::DIM_W'(1);
            end else begin
              state_d = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      z_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      z_q     <= z_d;
    end
  end

  always_comb begin
    cmd_o.wr_a = accept && (req_type_i == mm_pkg::REQ_LOAD_A) && row_in_a && col_in_a;
    cmd_o.wr_b = accept && (req_type_i == mm_pkg::REQ_LOAD_B) && row_in_b && col_in_b;
    cmd_o.rd_en          = (state_q == ST_RUN);
    cmd_o.rd_addr_a      = {i_q, z_q};
    cmd_o.rd_addr_b      = {z_q, j_q};
    cmd_o.tag.first      = (z_q == '0);
    cmd_o.tag.lastk      = last_z;
    cmd_o.tag.last_elem  = last_i && last_j;
    cmd_o.tag.row        = mm_pkg::IDX_W'(i_q);
    cmd_o.tag.col        = mm_pkg::IDX_W'(j_q);
  end

endmodule

`default_nettype wire

### rtl/mm_datapath.sv
// mm_datapath: operand stores, multiplier and accumulator with saturation.
// Depends on mm_pkg; commanded by mm_ctrl.
`default_nettype none

module mm_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mm_pkg::mm_cmd_t                     cmd_i,
  input  wire logic [mm_pkg::IDX_W-1:0]            row_index_i,
  input  wire logic [mm_pkg::IDX_W-1:0]            col_index_i,
  input  wire logic signed [mm_pkg::VAL_W-1:0]     element_value_i,
  output mm_pkg::mm_status_t                       status_o,
  output logic                                     out_valid_o,
  output logic [mm_pkg::IDX_W-1:0]                 out_row_o,
  output logic [mm_pkg::IDX_W-1:0]                 out_col_o,
  output logic signed [mm_pkg::PROD_W-1:0]         product_value_o,
  output logic                                     last_element_o
);

  logic [mm_pkg::ELEM_WIDTH-1:0] store_a [mm_pkg::DEPTH];
  logic [mm_pkg::ELEM_WIDTH-1:0] store_b [mm_pkg::DEPTH];

  logic [mm_pkg::ADDR_W-1:0]            wr_addr;
  logic signed [mm_pkg::ELEM_WIDTH-1:0] rd_a_q, rd_b_q;
  logic                                 s1_valid_q, s2_valid_q;
  mm_pkg::mm_tag_t                      s1_tag_q, s2_tag_q;
  logic signed [mm_pkg::MUL_W-1:0]      prod_q;
  logic signed [mm_pkg::ACC_W-1:0]      acc_q, acc_base, sum_d, sat_d;
  logic                                 out_valid_q;
  logic [mm_pkg::IDX_W-1:0]             out_row_q, out_col_q;
  logic signed [mm_pkg::PROD_W-1:0]     out_val_q;
  logic                                 out_last_q;

  assign wr_addr = {row_index_i[mm_pkg::DIM_W-1:0], col_index_i[mm_pkg::DIM_W-1:0]};

  // Stores: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      store_a[wr_addr] <= element_value_i[mm_pkg::ELEM_WIDTH-1:0];
    end
    if (cmd_i.wr_b) begin
      store_b[wr_addr] <= element_value_i[mm_pkg::ELEM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q   <= store_a[cmd_i.rd_addr_a];
    rd_b_q   <= store_b[cmd_i.rd_addr_b];
    s1_tag_q <= cmd_i.tag;
    prod_q   <= rd_a_q * rd_b_q;
    s2_tag_q <= s1_tag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.rd_en;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_comb begin
    acc_base = s2_tag_q.first ? '0 : acc_q;
    sum_d    = acc_base + mm_pkg::ACC_W'(prod_q);
    if (sum_d > mm_pkg::SAT_HI) begin
      sat_d = mm_pkg::SAT_HI;
    end else if (sum_d < mm_pkg::SAT_LO) begin
      sat_d = mm_pkg::SAT_LO;
    end else begin
      sat_d = sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      acc_q <= sum_d;
    end
    if (s2_valid_q && s2_tag_q.lastk) begin
      out_row_q  <= s2_tag_q.row;
      out_col_q  <= s2_tag_q.col;
      out_val_q  <= sat_d[mm_pkg::PROD_W-1:0];
      out_last_q <= s2_tag_q.last_elem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s2_valid_q && s2_tag_q.lastk;
    end
  end

  assign status_o.pipe_busy = s1_valid_q || s2_valid_q;
  assign out_valid_o        = out_valid_q;
  assign out_row_o          = out_row_q;
  assign out_col_o          = out_col_q;
  assign product_value_o    = out_val_q;
  assign last_element_o     = out_valid_q && out_last_q;

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for matrix_multiply_core: loads operand elements, runs products
// and compares every streamed element of C against a predictor kept in this file.
// Depends on mm_pkg for the port widths, request codes and register indexes.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam longint     PROD_MAX   = (longint'(1) <<< (mm_pkg::PROD_W - 1)) - 1;
  localparam longint     PROD_MIN   = -PROD_MAX - 1;
  localparam int         TAIL_CYCLES = 8;

  typedef struct {
    logic [mm_pkg::IDX_W-1:0]        row;
    logic [mm_pkg::IDX_W-1:0]        col;
    logic signed [mm_pkg::PROD_W-1:0] value;
    logic                            last;
  } mm_result_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             start = 1'b0;
  logic                             busy;
  logic [mm_pkg::REQ_W-1:0]         req_type_i = '0;
  logic [mm_pkg::IDX_W-1:0]         row_index_i = '0;
  logic [mm_pkg::IDX_W-1:0]         col_index_i = '0;
  logic signed [mm_pkg::VAL_W-1:0]  element_value_i = '0;
  logic                             out_valid_o;
  logic [mm_pkg::IDX_W-1:0]         out_row_o;
  logic [mm_pkg::IDX_W-1:0]         out_col_o;
  logic signed [mm_pkg::PROD_W-1:0] product_value_o;
  logic                             last_element_o;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [mm_pkg::PADDR_W-1:0]       paddr = '0;
  logic [mm_pkg::PDATA_W-1:0]       pwdata = '0;
  logic [mm_pkg::PDATA_W-1:0]       prdata;
  logic                             pready;

  // Predictor state
  logic signed [15:0] a_elems [64];
  logic signed [15:0] b_elems [64];
  bit                 a_loaded [64];
  bit                 b_loaded [64];
  logic [3:0]         rows_reg  = 4'd8;
  logic [3:0]         inner_reg = 4'd8;
  logic [3:0]         cols_reg  = 4'd8;

  mm_result_t expected_products [$];
  mm_result_t check_want;
  int         fail_count = 0;
  int         burst_left = 0;

  matrix_multiply_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .last_element_o  (last_element_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic int active_size(input logic [3:0] r);
    if (r == 4'd0) begin
      return 1;
    end
    if (int'(r) > mm_pkg::MAX_DIM) begin
      return mm_pkg::MAX_DIM;
    end
    return int'(r);
  endfunction

  function automatic logic [15:0] rand_element();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      return 16'h8000;
    end else if (pick < 4) begin
      return 16'h7FFF;
    end else if (pick == 4) begin
      return 16'h0000;
    end
    return 16'($urandom());
  endfunction

  function automatic logic [3:0] pick_dim();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return 4'd0;
      1: return 4'd15;
      2: return 4'd8;
      3: return 4'($urandom_range(0, 15));
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  // Send one request; update the predictor at the edge that completes the transfer
  task automatic send_item(input logic [1:0] req, input logic [2:0] row,
                           input logic [2:0] col, input logic [15:0] value);
    int         nr;
    int         nk;
    int         nc;
    int         gap;
    longint     acc;
    mm_result_t item;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    start           <= 1'b1;
    req_type_i      <= req;
    row_index_i     <= row;
    col_index_i     <= col;
    element_value_i <= value;
    do @(posedge clk_i); while (busy);
    nr = active_size(rows_reg);
    nk = active_size(inner_reg);
    nc = active_size(cols_reg);
    case (req)
      mm_pkg::REQ_LOAD_A: begin
        if (row < nr && col < nk) begin
          a_elems[{row, col}]  = value;
          a_loaded[{row, col}] = 1'b1;
        end
      end
      mm_pkg::REQ_LOAD_B: begin
        if (row < nk && col < nc) begin
          b_elems[{row, col}]  = value;
          b_loaded[{row, col}] = 1'b1;
        end
      end
      mm_pkg::REQ_COMPUTE: begin
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            acc = 0;
            for (int z = 0; z < nk; z++) begin
              acc += longint'(a_elems[i * 8 + z]) * longint'(b_elems[z * 8 + j]);
            end
            if (acc > PROD_MAX) begin
              acc = PROD_MAX;
            end else if (acc < PROD_MIN) begin
              acc = PROD_MIN;
            end
            item.row   = 3'(i);
            item.col   = 3'(j);
            item.value = acc[mm_pkg::PROD_W-1:0];
            item.last  = (i == nr - 1) && (j == nc - 1);
            expected_products.push_back(item);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Load every operand the product will read that has not been written yet, then compute
  task automatic run_product();
    int nr;
    int nk;
    int nc;
    nr = active_size(rows_reg);
    nk = active_size(inner_reg);
    nc = active_size(cols_reg);
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nk; c++) begin
        if (!a_loaded[r * 8 + c]) begin
          send_item(mm_pkg::REQ_LOAD_A, 3'(r), 3'(c), rand_element());
        end
      end
    end
    for (int r = 0; r < nk; r++) begin
      for (int c = 0; c < nc; c++) begin
        if (!b_loaded[r * 8 + c]) begin
          send_item(mm_pkg::REQ_LOAD_B, 3'(r), 3'(c), rand_element());
        end
      end
    end
    send_item(mm_pkg::REQ_COMPUTE, 3'($urandom()), 3'($urandom()), 16'($urandom()));
  endtask

  // Drop start, drain all results and let the pipeline settle
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Write one register, then read it back
  task automatic write_register(input logic [1:0] index, input logic [3:0] value);
    logic [31:0] upper;
    upper = $urandom();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {upper[27:0], value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (index)
      mm_pkg::REG_ROWS:  rows_reg  = value;
      mm_pkg::REG_INNER: inner_reg = value;
      mm_pkg::REG_COLS:  cols_reg  = value;
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[3:0] !== value) begin
      $error("prdata: expected %0d, got %0d", value, prdata[3:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_dims(input logic [3:0] rows, input logic [3:0] inner,
                          input logic [3:0] cols);
    wait_idle();
    write_register(mm_pkg::REG_ROWS, rows);
    write_register(mm_pkg::REG_INNER, inner);
    write_register(mm_pkg::REG_COLS, cols);
  endtask

  task automatic test_default_dims();
    run_product();
  endtask

  // All-minimum operands along the inner dimension push the sum past the top of the range
  task automatic test_saturation();
    for (int k = 0; k < 8; k++) begin
      send_item(mm_pkg::REQ_LOAD_A, 3'd0, 3'(k), 16'h8000);
      send_item(mm_pkg::REQ_LOAD_A, 3'd1, 3'(k), 16'h7FFF);
      send_item(mm_pkg::REQ_LOAD_B, 3'(k), 3'd0, 16'h8000);
      send_item(mm_pkg::REQ_LOAD_B, 3'(k), 3'd1, 16'h7FFF);
    end
    run_product();
  endtask

  task automatic test_dim_clamping();
    set_dims(4'd0, 4'd15, 4'd1);
    run_product();
    set_dims(4'd15, 4'd0, 4'd15);
    run_product();
  endtask

  // Out-of-range loads and the unused request type must leave the stores untouched
  task automatic test_ignored_requests();
    set_dims(4'd3, 4'd2, 4'd5);
    send_item(mm_pkg::REQ_LOAD_A, 3'd3, 3'd0, 16'h1234);
    send_item(mm_pkg::REQ_LOAD_A, 3'd7, 3'd1, 16'hFFFF);
    send_item(mm_pkg::REQ_LOAD_A, 3'd0, 3'd2, 16'h8000);
    send_item(mm_pkg::REQ_LOAD_A, 3'd2, 3'd7, 16'h7FFF);
    send_item(mm_pkg::REQ_LOAD_B, 3'd2, 3'd0, 16'h5A5A);
    send_item(mm_pkg::REQ_LOAD_B, 3'd0, 3'd5, 16'hA5A5);
    send_item(mm_pkg::REQ_LOAD_B, 3'd7, 3'd7, 16'hFFFF);
    send_item(REQ_UNUSED, 3'd0, 3'd0, 16'h0001);
    send_item(REQ_UNUSED, 3'd7, 3'd7, 16'hFFFF);
    send_item(mm_pkg::REQ_LOAD_A, 3'd2, 3'd1, 16'hFFFF);
    send_item(mm_pkg::REQ_LOAD_B, 3'd1, 3'd4, 16'h0001);
    run_product();
    set_dims(4'd8, 4'd8, 4'd8);
    run_product();
  endtask

  task automatic test_random_phases();
    int nr;
    int nk;
    int nc;
    int pick;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_dims(4'd1, 4'd1, 4'd1);
        1: set_dims(4'd8, 4'd8, 4'd8);
        default: set_dims(pick_dim(), pick_dim(), pick_dim());
      endcase
      nr = active_size(rows_reg);
      nk = active_size(inner_reg);
      nc = active_size(cols_reg);
      repeat (4) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_item(mm_pkg::REQ_LOAD_A, 3'($urandom_range(0, nr - 1)),
                    3'($urandom_range(0, nk - 1)), rand_element());
        end else if (pick < 80) begin
          send_item(mm_pkg::REQ_LOAD_B, 3'($urandom_range(0, nk - 1)),
                    3'($urandom_range(0, nc - 1)), rand_element());
        end else if (pick < 85) begin
          send_item(REQ_UNUSED, 3'($urandom()), 3'($urandom()), 16'($urandom()));
        end else if (pick < 90) begin
          // Load anywhere; may fall outside the active size
          send_item(2'($urandom_range(0, 1)), 3'($urandom()), 3'($urandom()),
                    rand_element());
        end else begin
          run_product();
        end
      end
      run_product();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (expected_products.size() == 0) begin
        $error("unexpected product element at row %0d col %0d", out_row_o, out_col_o);
        fail_count++;
      end else begin
        check_want = expected_products.pop_front();
        if (out_row_o !== check_want.row) begin
          $error("out_row: expected %0d, got %0d", check_want.row, out_row_o);
          fail_count++;
        end
        if (out_col_o !== check_want.col) begin
          $error("out_col: expected %0d, got %0d", check_want.col, out_col_o);
          fail_count++;
        end
        if (product_value_o !== check_want.value) begin
          $error("product_value: expected %0d, got %0d", check_want.value, product_value_o);
          fail_count++;
        end
        if (last_element_o !== check_want.last) begin
          $error("last_element: expected %0d, got %0d", check_want.last, last_element_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_dims();
    test_saturation();
    test_dim_clamping();
    test_ignored_requests();
    test_random_phases();
    wait_idle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
